### rtl/mgt_pkg.sv
// Shared types, constants and command/status structures for the transit timer.
package mgt_pkg;

    localparam int GATE_COUNT = 11;
    localparam int LEVELS_W   = 11;
    localparam int ELAPSED_W  = 17;
    localparam int TIMEOUT_W  = 16;
    localparam int RUN_W      = 8;
    localparam int INDEX_W    = 4;
    localparam int IDX_W      = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(60000);
    localparam logic [IDX_W-1:0]     LAST_GATE     = IDX_W'(GATE_COUNT - 1);

    typedef logic [GATE_COUNT-1:0] gate_mask_t;

    typedef enum logic
    {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        CAUSE_ALL     = 2'd0,
        CAUSE_LAST    = 2'd1,
        CAUSE_TIMEOUT = 2'd2
    } cause_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_ARMED,
        ST_RUNNING,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef struct packed
    {
        logic first;
        logic tick;
        logic latch_cause;
        logic emit_load;
        logic finish;
    } dp_cmd_t;

    typedef struct packed
    {
        logic lv_any;
        logic run_done;
        logic out_free;
        logic emit_last;
    } dp_status_t;

endpackage

### rtl/mgt_ctrl.sv
// Controller state machine for the transit timer: run phases and result emission.
module mgt_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                op,
    output logic                in_stall,
    input  mgt_pkg::dp_status_t status,
    output mgt_pkg::dp_cmd_t    cmd
);
    import mgt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg == ST_CHECK) || (state_reg == ST_EMIT);
        accept     = in_valid && !in_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_START))
                begin
                    state_next = ST_ARMED;
                end
            end
            ST_ARMED:
            begin
                if (accept && (op == OP_TICK) && status.lv_any)
                begin
                    cmd.first  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_RUNNING:
            begin
                if (accept && (op == OP_TICK))
                begin
                    cmd.tick   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.run_done)
                begin
                    cmd.latch_cause = 1'b1;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    state_next = ST_RUNNING;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/mgt_datapath.sv
// Datapath of the transit timer: elapsed count, capture store, end checks, output register.
module mgt_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mgt_pkg::LEVELS_W-1:0]      gate_levels,
    input  logic                              timeout_ticks_wr,
    input  logic [mgt_pkg::TIMEOUT_W-1:0]     timeout_ticks,
    input  mgt_pkg::dp_cmd_t                  cmd,
    output mgt_pkg::dp_status_t               status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mgt_pkg::RUN_W-1:0]         run_id,
    output logic [mgt_pkg::INDEX_W-1:0]       gate_index,
    output logic                              gate_seen,
    output logic [mgt_pkg::ELAPSED_W-1:0]     gate_time,
    output logic [1:0]                        end_cause,
    output logic                              last
);
    import mgt_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_next;
    gate_mask_t           seen_reg;
    gate_mask_t           lv;
    gate_mask_t           fresh;
    logic [ELAPSED_W-1:0] cap_reg [GATE_COUNT];
    logic [RUN_W-1:0]     run_counter_reg;
    cause_t               cause_reg;
    cause_t               cause_next;
    logic [IDX_W-1:0]     idx_reg;
    logic                 out_valid_reg;
    logic [RUN_W-1:0]     run_id_reg;
    logic [INDEX_W-1:0]   gate_index_reg;
    logic                 gate_seen_reg;
    logic [ELAPSED_W-1:0] gate_time_reg;
    cause_t               end_cause_reg;
    logic                 last_reg;
    logic                 all_seen;
    logic                 last_seen;
    logic                 timed_out;

    // Gates beyond the input width are never seen.
    assign lv = GATE_COUNT'(gate_levels);

    always_comb
    begin
        if (cmd.first)
        begin
            elapsed_next = '0;
            fresh        = lv;
        end
        else
        begin
            elapsed_next = (elapsed_reg == {ELAPSED_W{1'b1}}) ? elapsed_reg
                                                                : elapsed_reg + 1'b1;
            fresh        = lv & ~seen_reg;
        end
    end

    assign all_seen  = &seen_reg;
    assign last_seen = seen_reg[GATE_COUNT-1];
    assign timed_out = elapsed_reg > {1'b0, timeout_reg};

    // The lowest end cause wins when several conditions hold together.
    always_comb
    begin
        if (all_seen)
        begin
            cause_next = CAUSE_ALL;
        end
        else if (last_seen)
        begin
            cause_next = CAUSE_LAST;
        end
        else
        begin
            cause_next = CAUSE_TIMEOUT;
        end
    end

    assign status.lv_any    = |lv;
    assign status.run_done  = all_seen || last_seen || timed_out;
    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.emit_last = (idx_reg == LAST_GATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            elapsed_reg     <= '0;
            seen_reg        <= '0;
            run_counter_reg <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
            cause_reg       <= CAUSE_ALL;
        end
        else
        begin
            if (timeout_ticks_wr)
            begin
                timeout_reg <= timeout_ticks;
            end
            if (cmd.first || cmd.tick)
            begin
                elapsed_reg <= elapsed_next;
                seen_reg    <= (cmd.first ? '0 : seen_reg) | fresh;
            end
            if (cmd.latch_cause)
            begin
                cause_reg <= cause_next;
            end
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_reg + 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                elapsed_reg     <= '0;
                seen_reg        <= '0;
                idx_reg         <= '0;
                run_counter_reg <= run_counter_reg + 1'b1;
            end
        end
    end

    // Capture store: only entries whose seen bit is set are ever reported.
    always_ff @(posedge clk)
    begin
        for (int g = 0; g < GATE_COUNT; g++)
        begin
            if ((cmd.first || cmd.tick) && fresh[g])
            begin
                cap_reg[g] <= elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            run_id_reg     <= run_counter_reg;
            gate_index_reg <= INDEX_W'(idx_reg);
            gate_seen_reg  <= seen_reg[idx_reg];
            gate_time_reg  <= seen_reg[idx_reg] ? cap_reg[idx_reg] : '0;
            end_cause_reg  <= cause_reg;
            last_reg       <= (idx_reg == LAST_GATE);
        end
    end

    assign out_valid  = out_valid_reg;
    assign run_id     = run_id_reg;
    assign gate_index = gate_index_reg;
    assign gate_seen  = gate_seen_reg;
    assign gate_time  = gate_time_reg;
    assign end_cause  = end_cause_reg;
    assign last       = last_reg;

endmodule

### rtl/multi_gate_transit_timer.sv
// Top level of the multi-gate transit timer: controller and datapath.
// A start command beat is taken without a stall, as is a tick beat that finds the block
// idle, or armed with no gate broken. A tick beat that starts or continues a run is taken
// and the capture store updated, and then the end conditions are checked while the
// input is stalled in a separate check state. When a run ends the block sends GATE_COUNT
// result beats from its output register, one per cycle while the output is not stalled,
// and holds stall on the input until the final beat is loaded; the run is then
// closed and the next beat can be taken in the following cycle. The timeout
// register may be written at any time the block is idle and takes effect at once.
module multi_gate_transit_timer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [mgt_pkg::LEVELS_W-1:0]      gate_levels,
    input  logic                              timeout_ticks_wr,
    input  logic [mgt_pkg::TIMEOUT_W-1:0]     timeout_ticks,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mgt_pkg::RUN_W-1:0]         run_id,
    output logic [mgt_pkg::INDEX_W-1:0]       gate_index,
    output logic                              gate_seen,
    output logic [mgt_pkg::ELAPSED_W-1:0]     gate_time,
    output logic [1:0]                        end_cause,
    output logic                              last
);
    import mgt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mgt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mgt_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .gate_levels      (gate_levels),
        .timeout_ticks_wr (timeout_ticks_wr),
        .timeout_ticks    (timeout_ticks),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .run_id           (run_id),
        .gate_index       (gate_index),
        .gate_seen        (gate_seen),
        .gate_time        (gate_time),
        .end_cause        (end_cause),
        .last             (last)
    );

endmodule

### rtl/mgt_checker.sv
// Port-level checker for the transit timer, bound to the top level.
module mgt_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [mgt_pkg::RUN_W-1:0]         run_id,
    input logic [mgt_pkg::INDEX_W-1:0]       gate_index,
    input logic                              gate_seen,
    input logic [mgt_pkg::ELAPSED_W-1:0]     gate_time,
    input logic [1:0]                        end_cause,
    input logic                              last
);
    import mgt_pkg::*;

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(gate_time) && $stable(gate_index) && $stable(run_id))
    else $error("stalled result beat changed");

    // A gate that was never broken reports no time.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !gate_seen |-> gate_time == '0)
    else $error("unseen gate reports a time");

    // The final beat of a run belongs to the highest gate.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> gate_index == INDEX_W'(GATE_COUNT - 1))
    else $error("last flag on wrong gate");

    // A run ended by full capture reports every gate as seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (end_cause == CAUSE_ALL) |-> gate_seen)
    else $error("gate unseen in a fully captured run");

endmodule

bind multi_gate_transit_timer mgt_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .run_id     (run_id),
    .gate_index (gate_index),
    .gate_seen  (gate_seen),
    .gate_time  (gate_time),
    .end_cause  (end_cause),
    .last       (last)
);
